// ===== src/itoa_pkg.sv =====
// Shared constants and helpers for the signed integer to decimal text converter.
// Used by signed_int_to_decimal_ascii_top and by itoa_chk; depends on nothing else.
package itoa_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Number of decimal digits in 2^(w-1), the largest magnitude of a w-bit value.
  function automatic int digit_count(input int w);
    longint unsigned v;
    int n;
    v = 64'd1 << (w - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 64'd0) begin
        v = v / 64'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// Signed integer to decimal ASCII converter: a magnitude stage, a pipelined
// shift-and-add-3 binary to BCD converter and a character serializer.
// Depends on itoa_pkg.
//
//   channel | ports                          | one word carries
//   --------+--------------------------------+------------------------------
//   input   | in_valid, in_ready, in_value   | one signed integer
//   output  | out_valid, out_ready,          | one ASCII character, with last
//           | out_char_code, out_last        | set on the final one
//
// A word reaches the serializer after 1 + NS register stages (5 at 32 bits).
// The serializer emits one character per cycle while out_ready is high; an integer
// has 1 to 11 characters at 32 bits. The serializer loads the next integer in the
// cycle its last character leaves. Reset is synchronous and clears all valid bits;
// a stall holds each full stage whose successor is full, so empty stages still fill.
module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_char_code,
  output logic                          out_last
);

  localparam int W     = VALUE_WIDTH;
  localparam int ND    = itoa_pkg::digit_count(VALUE_WIDTH);
  localparam int BW    = 4 * ND;
  localparam int IW    = $clog2(ND);
  localparam int NS    = ((W + 7) / 8 < 3) ? 3 : (W + 7) / 8;
  localparam int STEPS = (W + NS - 1) / NS;

  logic [W-1:0]  bin_r [0:NS];
  logic [BW-1:0] bcd_r [1:NS];
  logic [NS:0]   neg_r;
  logic [NS:0]   v_r;
  logic [NS+1:0] rdy;

  logic          busy_r;
  logic          sign_r;
  logic [IW-1:0] idx_r;
  logic [BW-1:0] digits_r;
  logic [IW-1:0] msd;
  logic          load;
  logic [3:0]    cur_digit;

  assign in_ready = rdy[0];

  for (genvar s = 0; s <= NS; s++) begin : g_rdy
    assign rdy[s] = !v_r[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      neg_r[0] <= in_value[W-1];
      bin_r[0] <= in_value[W-1] ? (~in_value + 1'b1) : in_value;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_dd
    logic [BW-1:0] bcd_in;
    logic [W-1:0]  bin_c;
    logic [BW-1:0] bcd_c;

    if (s == 1) begin : g_first
      assign bcd_in = '0;
    end else begin : g_rest
      assign bcd_in = bcd_r[s-1];
    end

    always_comb begin
      bin_c = bin_r[s-1];
      bcd_c = bcd_in;
      for (int j = 0; j < STEPS; j++) begin
        if ((s - 1) * STEPS + j < W) begin
          for (int d = 0; d < ND; d++) begin
            if (bcd_c[4*d +: 4] >= 4'd5) begin
              bcd_c[4*d +: 4] = bcd_c[4*d +: 4] + 4'd3;
            end
          end
          bcd_c = {bcd_c[BW-2:0], bin_c[W-1]};
          bin_c = {bin_c[W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_r[s-1];
      end
      if (rdy[s] && v_r[s-1]) begin
        bin_r[s] <= bin_c;
        bcd_r[s] <= bcd_c;
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  always_comb begin
    msd = '0;
    for (int d = 0; d < ND; d++) begin
      if (bcd_r[NS][4*d +: 4] != 4'd0) begin
        msd = IW'(d);
      end
    end
  end

  assign rdy[NS+1] = !busy_r || (out_ready && out_last);
  assign load      = rdy[NS+1] && v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r   <= 1'b1;
      sign_r   <= neg_r[NS];
      idx_r    <= msd;
      digits_r <= bcd_r[NS];
    end else if (out_valid && out_ready) begin
      if (out_last) begin
        busy_r <= 1'b0;
      end else if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  assign cur_digit     = digits_r[4*idx_r +: 4];
  assign out_valid     = busy_r;
  assign out_char_code = sign_r ? itoa_pkg::CHAR_MINUS : (itoa_pkg::CHAR_ZERO + {4'd0, cur_digit});
  assign out_last      = !sign_r && (idx_r == '0);

endmodule

// ===== src/itoa_chk.sv =====
// Port-level checker for signed_int_to_decimal_ascii_top, bound to the top level.
// Depends on itoa_pkg.
module itoa_chk #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [VALUE_WIDTH-1:0] in_value,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [7:0]                    out_char_code,
  input logic                          out_last
);

  // An offered input word holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_value))
    else $error("input word changed while waiting");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("output word changed while stalled");

  // Every character is a minus sign or a decimal digit.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == itoa_pkg::CHAR_MINUS) ||
                  ((out_char_code >= itoa_pkg::CHAR_ZERO) &&
                   (out_char_code <= itoa_pkg::CHAR_ZERO + 8'd9)))
    else $error("character outside the decimal set");

  // A minus sign never ends a number.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == itoa_pkg::CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last");

  // A minus sign is followed at once by a nonzero leading digit.
  a_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_char_code == itoa_pkg::CHAR_MINUS) |=>
      out_valid && (out_char_code != itoa_pkg::CHAR_MINUS) &&
      (out_char_code != itoa_pkg::CHAR_ZERO))
    else $error("bad character after minus sign");

endmodule

bind signed_int_to_decimal_ascii_top itoa_chk #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_itoa_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_value     (in_value),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_char_code(out_char_code),
  .out_last     (out_last)
);

// ===== verif/signed_int_to_decimal_ascii_top_tb.sv =====
// Testbench for signed_int_to_decimal_ascii_top: drives signed 32-bit words and checks the
// decimal ASCII characters against a built-in text predictor, under random idling and back
// pressure. Depends on itoa_pkg and the converter RTL.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top_tb;

  localparam int VALUE_WIDTH = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DIR_ROWS = 20;
  localparam longint MAG_MAX_POS = 64'd2147483647;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] in_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    out_char_code;
  logic                          out_last;

  text_char_t expected_chars[$];
  bit         idle_on = 1'b1;
  int         hold_token = 0;
  int         mismatches = 0;
  int         words_sent = 0;
  int         chars_seen = 0;
  int         negatives_sent = 0;
  int         input_stalls = 0;
  int         hold_offs = 0;
  int         cycle_count = 0;

  logic [31:0] dir_value [DIR_ROWS] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'd9, 32'd10, 32'hFFFF_FFF6, 32'd99, 32'd100,
    32'hFFFF_FF9C, 32'd999999999, 32'd1000000000, 32'hC465_3600, 32'h8000_0001,
    32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, 32'd7
  };
  string dir_text [DIR_ROWS] = '{
    "0", "1", "-1", "2147483647", "-2147483648",
    "9", "10", "", "", "",
    "", "", "", "", "",
    "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_top #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d characters outstanding.",
               cycle_count, expected_chars.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Decimal text of one word: optional minus sign, then digits without leading zeros.
  function automatic void queue_decimal_text(input logic [31:0] raw);
    logic [31:0] mag;
    logic [7:0]  digits[$];
    bit          neg;
    neg = raw[31];
    mag = neg ? (~raw + 32'd1) : raw;
    do begin
      digits.push_front(itoa_pkg::CHAR_ZERO + 8'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (neg) expected_chars.push_back('{code: itoa_pkg::CHAR_MINUS, last: 1'b0});
    foreach (digits[i]) begin
      expected_chars.push_back('{code: digits[i], last: (i == digits.size() - 1)});
    end
  endfunction

  function automatic void queue_typed_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      expected_chars.push_back('{code: text[i], last: (i == text.len() - 1)});
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic longint pow10(input int k);
    longint p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Mix of full-range words, words of a chosen digit count, powers of ten and extremes.
  function automatic logic [31:0] draw_value();
    longint lo;
    longint hi;
    longint mag;
    int     sel;
    int     digits;
    bit     neg;
    sel = $urandom_range(0, 9);
    neg = $urandom_range(0, 1);
    mag = 0;
    case (sel)
      0, 1, 2, 3: begin
        return $urandom();
      end
      4, 5, 6: begin
        digits = $urandom_range(1, 10);
        lo = (digits == 1) ? 0 : pow10(digits - 1);
        hi = pow10(digits) - 1;
        if (hi > MAG_MAX_POS) hi = MAG_MAX_POS + (neg ? 1 : 0);
        mag = lo + ({32'd0, $urandom()} % (hi - lo + 1));
      end
      7: begin
        mag = pow10($urandom_range(0, 9)) - $urandom_range(0, 1);
      end
      8: begin
        mag = $urandom_range(0, 20);
      end
      default: begin
        mag = MAG_MAX_POS + 1 - $urandom_range(0, 3);
        if (!neg && mag > MAG_MAX_POS) mag = MAG_MAX_POS;
      end
    endcase
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  task automatic send_word(input logic [31:0] v, input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do begin
      @(posedge clk);
      if (!in_ready) input_stalls++;
    end while (!in_ready);
    if (text.len() != 0) queue_typed_text(text);
    else queue_decimal_text(v);
    words_sent++;
    if (v[31]) negatives_sent++;
  endtask

  initial begin : rx_side
    int         stall_left;
    int         seen_hold;
    text_char_t want;
    stall_left = 0;
    seen_hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected character 0x%02h last=%0b", out_char_code, out_last);
        end else begin
          want = expected_chars.pop_front();
          if (out_char_code !== want.code || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       want.code, want.last, out_char_code, out_last);
          end
        end
      end
      if (hold_token != seen_hold) begin
        seen_hold = hold_token;
        stall_left = PRESSURE_CYCLES;
        hold_offs++;
      end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : tx_side
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) send_word(dir_value[i], dir_text[i]);

    repeat (150) send_word(draw_value(), "");

    idle_on <= 1'b0;
    repeat (60) send_word(draw_value(), "");

    hold_token <= hold_token + 1;
    repeat (40) send_word(draw_value(), "");

    idle_on <= 1'b1;
    repeat (150) send_word(draw_value(), "");
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d words (%0d negative) into %0d characters.",
             words_sent, negatives_sent, chars_seen);
    $display("Input stalled %0d cycles; %0d long output hold-off(s); %0d mismatches.",
             input_stalls, hold_offs, mismatches);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
